// File: rtl/erdl_pkg.sv
// ----------------------------------------------------------------------------
// erdl_pkg
// shared types and constants for the echo and reverb delay line unit
// ----------------------------------------------------------------------------
package erdl_pkg;

  localparam int DATA_W   = 32;
  localparam int LEN_W    = 18;
  localparam int MIX_W    = 17;
  localparam int FB_W     = 16;
  localparam int GAIN_W   = 17;
  localparam int COEF_W   = 18;
  localparam int PROD_W   = 50;
  localparam int ACC_W    = 51;
  localparam int RND_W    = ACC_W - 12;
  localparam int APB_AW   = 5;
  localparam int APB_DW   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [MIX_W-1:0]  MIX_ONE     = 17'd65536;
  localparam logic [FB_W-1:0]   FB_MAX      = 16'd40960;
  localparam logic [GAIN_W-1:0] IN_GAIN_MAX = 17'd98304;

  localparam logic [LEN_W-1:0]  ECHO_LENGTH_RST   = 18'd44100;
  localparam logic [LEN_W-1:0]  REVERB_LENGTH_RST = 18'd88200;
  localparam logic [MIX_W-1:0]  MIX_RST           = 17'd32768;
  localparam logic [FB_W-1:0]   FB_RST            = 16'd2048;
  localparam logic [GAIN_W-1:0] GAIN_RST          = 17'd4096;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ECHO_LENGTH       = 3'd0,
    REG_REVERB_LENGTH     = 3'd1,
    REG_ECHO_MIX          = 3'd2,
    REG_FEEDBACK_GAIN     = 3'd3,
    REG_ECHO_INPUT_GAIN   = 3'd4,
    REG_REVERB_MIX        = 3'd5,
    REG_REVERB_INPUT_GAIN = 3'd6
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ECHO_FB,
    ST_ECHO_MIX,
    ST_ECHO_OUT,
    ST_REV_FB,
    ST_REV_MIX,
    ST_REV_OUT
  } state_t;

  typedef struct packed {
    logic load_in;
    logic sel_rev;
    logic mul_fb;
    logic mul_mix;
    logic pass_echo;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0]  echo_length;
    logic [LEN_W-1:0]  reverb_length;
    logic [MIX_W-1:0]  echo_mix;
    logic [FB_W-1:0]   feedback_gain;
    logic [GAIN_W-1:0] echo_input_gain;
    logic [MIX_W-1:0]  reverb_mix;
    logic [GAIN_W-1:0] reverb_input_gain;
  } cfg_t;

  typedef struct packed {
    logic echo_clr;
    logic rev_clr;
  } clr_t;

  typedef struct packed {
    logic               clip;
    logic signed [DATA_W-1:0] value;
  } sat_t;

  function automatic sat_t sat32(input logic signed [RND_W-1:0] v);
    sat_t r;
    logic same;
    same = (&v[RND_W-1:DATA_W-1]) | ~(|v[RND_W-1:DATA_W-1]);
    if (same) begin
      r.clip  = 1'b0;
      r.value = v[DATA_W-1:0];
    end else if (v[RND_W-1]) begin
      r.clip  = 1'b1;
      r.value = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r.clip  = 1'b1;
      r.value = {1'b0, {(DATA_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// File: rtl/erdl_ram.sv
// ----------------------------------------------------------------------------
// erdl_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module erdl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: rtl/erdl_regs.sv
// ----------------------------------------------------------------------------
// erdl_regs
// apb configuration registers with range limiting and line clear strobes
// ----------------------------------------------------------------------------
module erdl_regs #(
  parameter int MAX_LINE_LENGTH = 131072
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [erdl_pkg::APB_AW-1:0]   paddr,
  input  logic [erdl_pkg::APB_DW-1:0]   pwdata,
  output logic [erdl_pkg::APB_DW-1:0]   prdata,
  output erdl_pkg::cfg_t                cfg,
  output erdl_pkg::clr_t                clr
);

  localparam int LEN_W = erdl_pkg::LEN_W;

  logic                 wr_en;
  erdl_pkg::reg_idx_t   idx;

  function automatic logic [LEN_W-1:0] limit_len(input logic [LEN_W-1:0] v);
    logic [LEN_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = LEN_W'(1);
    end else if (32'(v) > 32'(MAX_LINE_LENGTH)) begin
      r = LEN_W'(MAX_LINE_LENGTH);
    end
    return r;
  endfunction

  assign wr_en = psel & penable & pwrite;
  assign idx   = erdl_pkg::reg_idx_t'(paddr[erdl_pkg::APB_AW-1:2]);

  assign clr.echo_clr = wr_en && (idx == erdl_pkg::REG_ECHO_LENGTH);
  assign clr.rev_clr  = wr_en && (idx == erdl_pkg::REG_REVERB_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.echo_length       <= limit_len(erdl_pkg::ECHO_LENGTH_RST);
      cfg.reverb_length     <= limit_len(erdl_pkg::REVERB_LENGTH_RST);
      cfg.echo_mix          <= erdl_pkg::MIX_RST;
      cfg.feedback_gain     <= erdl_pkg::FB_RST;
      cfg.echo_input_gain   <= erdl_pkg::GAIN_RST;
      cfg.reverb_mix        <= erdl_pkg::MIX_RST;
      cfg.reverb_input_gain <= erdl_pkg::GAIN_RST;
    end else if (wr_en) begin
      unique case (idx)
        erdl_pkg::REG_ECHO_LENGTH: begin
          cfg.echo_length <= limit_len(pwdata[LEN_W-1:0]);
        end
        erdl_pkg::REG_REVERB_LENGTH: begin
          cfg.reverb_length <= limit_len(pwdata[LEN_W-1:0]);
        end
        erdl_pkg::REG_ECHO_MIX: begin
          cfg.echo_mix <= (pwdata[erdl_pkg::MIX_W-1:0] > erdl_pkg::MIX_ONE) ?
                          erdl_pkg::MIX_ONE : pwdata[erdl_pkg::MIX_W-1:0];
        end
        erdl_pkg::REG_FEEDBACK_GAIN: begin
          cfg.feedback_gain <= (pwdata[erdl_pkg::FB_W-1:0] > erdl_pkg::FB_MAX) ?
                               erdl_pkg::FB_MAX : pwdata[erdl_pkg::FB_W-1:0];
        end
        erdl_pkg::REG_ECHO_INPUT_GAIN: begin
          cfg.echo_input_gain <=
            (pwdata[erdl_pkg::GAIN_W-1:0] > erdl_pkg::IN_GAIN_MAX) ?
            erdl_pkg::IN_GAIN_MAX : pwdata[erdl_pkg::GAIN_W-1:0];
        end
        erdl_pkg::REG_REVERB_MIX: begin
          cfg.reverb_mix <= (pwdata[erdl_pkg::MIX_W-1:0] > erdl_pkg::MIX_ONE) ?
                            erdl_pkg::MIX_ONE : pwdata[erdl_pkg::MIX_W-1:0];
        end
        erdl_pkg::REG_REVERB_INPUT_GAIN: begin
          cfg.reverb_input_gain <=
            (pwdata[erdl_pkg::GAIN_W-1:0] > erdl_pkg::IN_GAIN_MAX) ?
            erdl_pkg::IN_GAIN_MAX : pwdata[erdl_pkg::GAIN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      erdl_pkg::REG_ECHO_LENGTH:       prdata = erdl_pkg::APB_DW'(cfg.echo_length);
      erdl_pkg::REG_REVERB_LENGTH:     prdata = erdl_pkg::APB_DW'(cfg.reverb_length);
      erdl_pkg::REG_ECHO_MIX:          prdata = erdl_pkg::APB_DW'(cfg.echo_mix);
      erdl_pkg::REG_FEEDBACK_GAIN:     prdata = erdl_pkg::APB_DW'(cfg.feedback_gain);
      erdl_pkg::REG_ECHO_INPUT_GAIN:   prdata = erdl_pkg::APB_DW'(cfg.echo_input_gain);
      erdl_pkg::REG_REVERB_MIX:        prdata = erdl_pkg::APB_DW'(cfg.reverb_mix);
      erdl_pkg::REG_REVERB_INPUT_GAIN: prdata = erdl_pkg::APB_DW'(cfg.reverb_input_gain);
      default:                         prdata = '0;
    endcase
  end

endmodule

// File: rtl/erdl_ctrl.sv
// ----------------------------------------------------------------------------
// erdl_ctrl
// sequencer for the echo pass, the reverb pass and the result transaction
// ----------------------------------------------------------------------------
module erdl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output erdl_pkg::dp_cmd_t cmd
);

  erdl_pkg::state_t state, state_next;
  logic             out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= erdl_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      erdl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = erdl_pkg::ST_ECHO_FB;
        end
      end
      erdl_pkg::ST_ECHO_FB: begin
        cmd.mul_fb = 1'b1;
        state_next = erdl_pkg::ST_ECHO_MIX;
      end
      erdl_pkg::ST_ECHO_MIX: begin
        cmd.mul_mix = 1'b1;
        state_next  = erdl_pkg::ST_ECHO_OUT;
      end
      erdl_pkg::ST_ECHO_OUT: begin
        cmd.pass_echo = 1'b1;
        state_next    = erdl_pkg::ST_REV_FB;
      end
      erdl_pkg::ST_REV_FB: begin
        cmd.sel_rev = 1'b1;
        cmd.mul_fb  = 1'b1;
        state_next  = erdl_pkg::ST_REV_MIX;
      end
      erdl_pkg::ST_REV_MIX: begin
        cmd.sel_rev = 1'b1;
        cmd.mul_mix = 1'b1;
        state_next  = erdl_pkg::ST_REV_OUT;
      end
      erdl_pkg::ST_REV_OUT: begin
        cmd.sel_rev = 1'b1;
        if (!out_valid || out_ready) begin
          cmd.load_out = 1'b1;
          state_next   = erdl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = erdl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    priority if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// File: rtl/erdl_dp.sv
// ----------------------------------------------------------------------------
// erdl_dp
// delay line memories, pointers, shared multiplier pair, rounding and clipping
// ----------------------------------------------------------------------------
module erdl_dp #(
  parameter int MAX_LINE_LENGTH = 131072,
  parameter int SAMPLE_BITS     = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  erdl_pkg::dp_cmd_t                    cmd,
  input  erdl_pkg::cfg_t                       cfg,
  input  erdl_pkg::clr_t                       clr,
  input  logic signed [SAMPLE_BITS-1:0]        sample_in,
  output logic signed [erdl_pkg::DATA_W-1:0]   sample_out,
  output logic                                 saturated
);

  localparam int DATA_W = erdl_pkg::DATA_W;
  localparam int PROD_W = erdl_pkg::PROD_W;
  localparam int ACC_W  = erdl_pkg::ACC_W;
  localparam int RND_W  = erdl_pkg::RND_W;
  localparam int COEF_W = erdl_pkg::COEF_W;
  localparam int LEN_W  = erdl_pkg::LEN_W;
  localparam int PTR_W  = $clog2(MAX_LINE_LENGTH);
  localparam int CMP_W  = (PTR_W + 1 > LEN_W) ? PTR_W + 1 : LEN_W;

  logic [PTR_W-1:0]                echo_ptr, rev_ptr, ptr_sel;
  logic [PTR_W:0]                  ptr_inc;
  logic                            echo_full, rev_full, wrap;
  logic [LEN_W-1:0]                len_sel;
  logic                            echo_we, rev_we;
  logic signed [DATA_W-1:0]        echo_rdata, rev_rdata, rd_val, x, d, mb;
  logic [erdl_pkg::GAIN_W-1:0]     gain_sel;
  logic [erdl_pkg::MIX_W-1:0]      mix_sel;
  logic signed [COEF_W-1:0]        ca, cb;
  logic signed [PROD_W-1:0]        pa, pb, pa_next, pb_next;
  logic signed [ACC_W-1:0]         acc;
  logic signed [RND_W-1:0]         r12, r16;
  erdl_pkg::sat_t                  s12, s16;
  logic                            clip;

  // an entry reads as zero until the pointer has wrapped once since clear
  always_comb begin
    if (cmd.sel_rev) begin
      rd_val   = rev_full ? rev_rdata : '0;
      gain_sel = cfg.reverb_input_gain;
      mix_sel  = cfg.reverb_mix;
      ptr_sel  = rev_ptr;
      len_sel  = cfg.reverb_length;
    end else begin
      rd_val   = echo_full ? echo_rdata : '0;
      gain_sel = cfg.echo_input_gain;
      mix_sel  = cfg.echo_mix;
      ptr_sel  = echo_ptr;
      len_sel  = cfg.echo_length;
    end
  end

  always_comb begin
    if (cmd.mul_fb) begin
      ca = $signed({1'b0, gain_sel});
      cb = $signed({2'b0, cfg.feedback_gain});
      mb = rd_val;
    end else begin
      ca = $signed({1'b0, erdl_pkg::MIX_ONE - mix_sel});
      cb = $signed({1'b0, mix_sel});
      mb = d;
    end
  end

  assign pa_next = PROD_W'(x) * PROD_W'(ca);
  assign pb_next = PROD_W'(mb) * PROD_W'(cb);

  assign acc = ACC_W'(pa) + ACC_W'(pb);
  assign r12 = RND_W'((acc + ACC_W'(2048)) >>> 12);
  assign r16 = RND_W'((acc + ACC_W'(32768)) >>> 16);
  assign s12 = erdl_pkg::sat32(r12);
  assign s16 = erdl_pkg::sat32(r16);

  assign ptr_inc = (PTR_W + 1)'(ptr_sel) + (PTR_W + 1)'(1);
  assign wrap    = CMP_W'(ptr_inc) >= CMP_W'(len_sel);
  assign echo_we = cmd.mul_mix && !cmd.sel_rev;
  assign rev_we  = cmd.mul_mix && cmd.sel_rev;

  erdl_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_LINE_LENGTH)
  ) u_echo_ram (
    .clk   (clk),
    .we    (echo_we),
    .addr  (echo_ptr),
    .wdata (s12.value),
    .rdata (echo_rdata)
  );

  erdl_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_LINE_LENGTH)
  ) u_rev_ram (
    .clk   (clk),
    .we    (rev_we),
    .addr  (rev_ptr),
    .wdata (s12.value),
    .rdata (rev_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      echo_ptr  <= '0;
      rev_ptr   <= '0;
      echo_full <= 1'b0;
      rev_full  <= 1'b0;
    end else begin
      if (clr.echo_clr) begin
        echo_ptr  <= '0;
        echo_full <= 1'b0;
      end else if (echo_we) begin
        echo_ptr <= wrap ? '0 : ptr_inc[PTR_W-1:0];
        if (wrap) begin
          echo_full <= 1'b1;
        end
      end
      if (clr.rev_clr) begin
        rev_ptr  <= '0;
        rev_full <= 1'b0;
      end else if (rev_we) begin
        rev_ptr <= wrap ? '0 : ptr_inc[PTR_W-1:0];
        if (wrap) begin
          rev_full <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x    <= DATA_W'(sample_in);
      clip <= 1'b0;
    end
    if (cmd.mul_fb) begin
      d <= rd_val;
    end
    if (cmd.mul_fb || cmd.mul_mix) begin
      pa <= pa_next;
      pb <= pb_next;
    end
    if (cmd.mul_mix) begin
      clip <= clip | s12.clip;
    end
    if (cmd.pass_echo) begin
      x    <= s16.value;
      clip <= clip | s16.clip;
    end
    if (cmd.load_out) begin
      sample_out <= s16.value;
      saturated  <= clip | s16.clip;
    end
  end

endmodule

// File: rtl/echo_reverb_delay_lines_unit.sv
// ----------------------------------------------------------------------------
// echo_reverb_delay_lines_unit
// two cascaded feedback delay lines, echo then reverb, with apb configuration
// ----------------------------------------------------------------------------
// A new sample is accepted only once the previous one has gone through every
// step: the idle step, then for each delay line the feedback products, the
// mix products with write-back and the output rounding, in turn, as set by
// the single shared multiplier pair and the one port of each line memory. The
// result waits in an output register;
// the unit stalls in its last step only while a previous result is untaken.
// Line memories need no clearing pass: after reset or a length write, a line
// reads as zero until its pointer first wraps, so a write takes effect at once.
module echo_reverb_delay_lines_unit #(
  parameter int MAX_LINE_LENGTH = 131072,
  parameter int SAMPLE_BITS     = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [erdl_pkg::APB_AW-1:0]         paddr,
  input  logic [erdl_pkg::APB_DW-1:0]         pwdata,
  output logic [erdl_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [erdl_pkg::DATA_W-1:0]  sample_out,
  output logic                                saturated
);

  erdl_pkg::cfg_t    cfg;
  erdl_pkg::clr_t    clr;
  erdl_pkg::dp_cmd_t cmd;

  assign pready = 1'b1;

  erdl_regs #(
    .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
  ) u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .clr     (clr)
  );

  erdl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  erdl_dp #(
    .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg        (cfg),
    .clr        (clr),
    .sample_in  (sample_in),
    .sample_out (sample_out),
    .saturated  (saturated)
  );

  a_accept_starts_echo: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (cmd.mul_fb && !cmd.sel_rev))
    else $error("echo pass did not follow an input transaction");

  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_in, cmd.mul_fb, cmd.mul_mix, cmd.pass_echo, cmd.load_out}))
    else $error("more than one datapath step at once");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !(cmd.mul_fb || cmd.mul_mix || cmd.pass_echo || cmd.load_out))
    else $error("input ready while datapath busy");

endmodule

// File: verif/echo_reverb_delay_lines_unit_test.sv
// ----------------------------------------------------------------------------
// echo_reverb_delay_lines_unit_test
// Checks the echo and reverb delay line unit against a built-in predictor.
// The APB port sets the line lengths, mixes and gains. Directed samples go
// through first: field extremes, clipping at both rails, out-of-range
// register values and the unused register slot. Random phases follow with
// random settings and random idling on both handshakes. Every output
// transaction is checked field by field against the predicted result.
// ----------------------------------------------------------------------------
module echo_reverb_delay_lines_unit_test;

  localparam int LINE_DEPTH = 131072;
  localparam int SAMPLE_W = 24;
  localparam int SETTLE_CYCLES = 12;
  localparam logic [erdl_pkg::APB_AW-1:0] SPARE_REG_ADDR = 5'd28;
  localparam longint CLIP_HI = 64'sd2147483647;
  localparam longint CLIP_LO = -64'sd2147483648;

  typedef struct packed {
    logic signed [erdl_pkg::DATA_W-1:0] level;
    logic clipped;
  } reverb_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [erdl_pkg::APB_AW-1:0] paddr;
  logic [erdl_pkg::APB_DW-1:0] pwdata;
  logic [erdl_pkg::APB_DW-1:0] prdata;
  logic pready;
  logic in_valid;
  logic in_ready;
  logic signed [SAMPLE_W-1:0] sample_in;
  logic out_valid;
  logic out_ready;
  logic signed [erdl_pkg::DATA_W-1:0] sample_out;
  logic saturated;

  logic signed [SAMPLE_W-1:0] pending_samples[$];
  reverb_result_t expected_outputs[$];
  bit in_fire;
  int send_idle_pct;
  int recv_stall_pct;
  int error_count;

  int echo_taps[int];
  int reverb_taps[int];
  int echo_ptr;
  int reverb_ptr;
  int echo_len;
  int reverb_len;
  int echo_wet;
  int fb_gain;
  int echo_gain;
  int reverb_wet;
  int reverb_gain;

  echo_reverb_delay_lines_unit #(
    .MAX_LINE_LENGTH(LINE_DEPTH),
    .SAMPLE_BITS(SAMPLE_W)
  ) dut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_in(sample_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sample_out(sample_out),
    .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("echo_reverb_delay_lines_unit_test: errors");
    $finish;
  end

  function automatic longint round_shift(input longint v, input int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic int clip32(input longint v, inout bit clip);
    if (v > CLIP_HI) begin
      clip = 1'b1;
      return int'(CLIP_HI);
    end
    if (v < CLIP_LO) begin
      clip = 1'b1;
      return int'(CLIP_LO);
    end
    return int'(v);
  endfunction

  function automatic int delay_line_step(input bit use_reverb, input int dry, input int in_gain,
                                         input int wet_mix, inout bit clip);
    int ptr;
    int len;
    int delayed;
    int stored;
    longint acc;
    ptr = use_reverb ? reverb_ptr : echo_ptr;
    len = use_reverb ? reverb_len : echo_len;
    if (use_reverb) delayed = reverb_taps.exists(ptr) ? reverb_taps[ptr] : 0;
    else delayed = echo_taps.exists(ptr) ? echo_taps[ptr] : 0;
    acc = longint'(dry) * longint'(in_gain) + longint'(delayed) * longint'(fb_gain);
    stored = clip32(round_shift(acc, 12), clip);
    ptr = (ptr + 1 >= len) ? 0 : ptr + 1;
    if (use_reverb) begin
      reverb_taps[reverb_ptr] = stored;
      reverb_ptr = ptr;
    end else begin
      echo_taps[echo_ptr] = stored;
      echo_ptr = ptr;
    end
    acc = longint'(dry) * longint'(int'(erdl_pkg::MIX_ONE) - wet_mix)
          + longint'(delayed) * longint'(wet_mix);
    return clip32(round_shift(acc, 16), clip);
  endfunction

  function automatic reverb_result_t predict_reverb_output(input logic signed [SAMPLE_W-1:0] s);
    reverb_result_t r;
    bit clip;
    int echo_out;
    clip = 1'b0;
    echo_out = delay_line_step(1'b0, int'(s), echo_gain, echo_wet, clip);
    r.level = delay_line_step(1'b1, echo_out, reverb_gain, reverb_wet, clip);
    r.clipped = clip;
    return r;
  endfunction

  function automatic int clamp_length(input logic [erdl_pkg::LEN_W-1:0] v);
    if (v == 0) return 1;
    if (int'(v) > LINE_DEPTH) return LINE_DEPTH;
    return int'(v);
  endfunction

  function automatic int clamp_to(input int v, input int hi);
    return (v > hi) ? hi : v;
  endfunction

  function automatic void apply_register(input logic [erdl_pkg::APB_AW-1:0] addr,
                                         input logic [31:0] d);
    case (addr[erdl_pkg::APB_AW-1:2])
      erdl_pkg::REG_ECHO_LENGTH: begin
        echo_len = clamp_length(d[erdl_pkg::LEN_W-1:0]);
        echo_taps.delete();
        echo_ptr = 0;
      end
      erdl_pkg::REG_REVERB_LENGTH: begin
        reverb_len = clamp_length(d[erdl_pkg::LEN_W-1:0]);
        reverb_taps.delete();
        reverb_ptr = 0;
      end
      erdl_pkg::REG_ECHO_MIX:
        echo_wet = clamp_to(int'(d[erdl_pkg::MIX_W-1:0]), int'(erdl_pkg::MIX_ONE));
      erdl_pkg::REG_FEEDBACK_GAIN:
        fb_gain = clamp_to(int'(d[erdl_pkg::FB_W-1:0]), int'(erdl_pkg::FB_MAX));
      erdl_pkg::REG_ECHO_INPUT_GAIN:
        echo_gain = clamp_to(int'(d[erdl_pkg::GAIN_W-1:0]), int'(erdl_pkg::IN_GAIN_MAX));
      erdl_pkg::REG_REVERB_MIX:
        reverb_wet = clamp_to(int'(d[erdl_pkg::MIX_W-1:0]), int'(erdl_pkg::MIX_ONE));
      erdl_pkg::REG_REVERB_INPUT_GAIN:
        reverb_gain = clamp_to(int'(d[erdl_pkg::GAIN_W-1:0]), int'(erdl_pkg::IN_GAIN_MAX));
      default: ;
    endcase
  endfunction

  function automatic logic [erdl_pkg::APB_AW-1:0] reg_addr(input erdl_pkg::reg_idx_t idx);
    return {idx, 2'b00};
  endfunction

  // random bits above the register width
  function automatic logic [31:0] with_noise(input int unsigned v, input int w);
    logic [31:0] m;
    m = (32'h1 << w) - 1;
    return ($urandom() & ~m) | (v & m);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    logic signed [SAMPLE_W-1:0] s;
    case ($urandom_range(9))
      0: s = 24'sh7FFFFF;
      1: s = 24'sh800000;
      2, 3: begin
        s = SAMPLE_W'($urandom_range(255));
        if ($urandom_range(1)) s = -s;
      end
      default: s = SAMPLE_W'($urandom());
    endcase
    return s;
  endfunction

  function automatic void queue_sample(input logic signed [SAMPLE_W-1:0] s);
    pending_samples.insert(pending_samples.size(), s);
  endfunction

  task automatic program_register(input logic [erdl_pkg::APB_AW-1:0] addr,
                                  input logic [31:0] d);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_register(addr, d);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_until_quiet();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_outputs.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic int unsigned pick_length();
    case ($urandom_range(9))
      0: return 0;
      1: return LINE_DEPTH;
      default: return $urandom_range(24, 1);
    endcase
  endfunction

  function automatic int unsigned pick_mix();
    if ($urandom_range(3) == 0)
      return $urandom_range(1) ? 0 : 65536 + $urandom_range(65535);
    return $urandom_range(65536);
  endfunction

  function automatic int unsigned pick_gain(input int unsigned top);
    if ($urandom_range(3) == 0) return $urandom_range(top);
    return $urandom_range(8192);
  endfunction

  task automatic shuffle_settings();
    program_register(reg_addr(erdl_pkg::REG_ECHO_LENGTH),
                     with_noise(pick_length(), erdl_pkg::LEN_W));
    program_register(reg_addr(erdl_pkg::REG_REVERB_LENGTH),
                     with_noise(pick_length(), erdl_pkg::LEN_W));
    program_register(reg_addr(erdl_pkg::REG_ECHO_MIX),
                     with_noise(pick_mix(), erdl_pkg::MIX_W));
    program_register(reg_addr(erdl_pkg::REG_FEEDBACK_GAIN),
                     with_noise(pick_gain(65535) >> 1, erdl_pkg::FB_W));
    program_register(reg_addr(erdl_pkg::REG_ECHO_INPUT_GAIN),
                     with_noise(pick_gain(131071), erdl_pkg::GAIN_W));
    program_register(reg_addr(erdl_pkg::REG_REVERB_MIX),
                     with_noise(pick_mix(), erdl_pkg::MIX_W));
    program_register(reg_addr(erdl_pkg::REG_REVERB_INPUT_GAIN),
                     with_noise(pick_gain(131071), erdl_pkg::GAIN_W));
  endtask

  // sender
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        sample_in <= pending_samples.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    reverb_result_t want;
    in_fire = 1'b0;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_outputs.size() == 0) begin
          $display("%0t unexpected output transaction sample_out %0d saturated %0b",
                   $time, sample_out, saturated);
          error_count++;
        end else begin
          want = expected_outputs.pop_front();
          if (sample_out !== want.level) begin
            $display("%0t sample_out expected %0d actual %0d", $time, want.level, sample_out);
            error_count++;
          end
          if (saturated !== want.clipped) begin
            $display("%0t saturated expected %0b actual %0b", $time, want.clipped, saturated);
            error_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        in_fire = 1'b1;
        expected_outputs.insert(expected_outputs.size(), predict_reverb_output(sample_in));
      end
    end
  end

  initial begin
    int phase;
    int n;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    sample_in = '0;
    out_ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    error_count = 0;
    echo_ptr = 0;
    reverb_ptr = 0;
    echo_len = clamp_length(erdl_pkg::ECHO_LENGTH_RST);
    reverb_len = clamp_length(erdl_pkg::REVERB_LENGTH_RST);
    echo_wet = int'(erdl_pkg::MIX_RST);
    fb_gain = int'(erdl_pkg::FB_RST);
    echo_gain = int'(erdl_pkg::GAIN_RST);
    reverb_wet = int'(erdl_pkg::MIX_RST);
    reverb_gain = int'(erdl_pkg::GAIN_RST);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings, field extremes
    pending_samples = '{24'sh7FFFFF, 24'sh800000, 24'sh000000, -24'sd1, 24'sh000001,
                        24'sh555555, 24'shAAAAAA, 24'sh400000};
    wait_until_quiet();

    // zero length acts as one, over-range mix and gains clamp, feedback runs away
    program_register(reg_addr(erdl_pkg::REG_ECHO_LENGTH), 32'h0);
    program_register(reg_addr(erdl_pkg::REG_REVERB_LENGTH), 32'h2);
    program_register(reg_addr(erdl_pkg::REG_ECHO_MIX), 32'h1FFFF);
    program_register(reg_addr(erdl_pkg::REG_FEEDBACK_GAIN), 32'hFFFF);
    program_register(reg_addr(erdl_pkg::REG_ECHO_INPUT_GAIN), 32'h1FFFF);
    program_register(reg_addr(erdl_pkg::REG_REVERB_MIX), 32'h1FFFF);
    program_register(reg_addr(erdl_pkg::REG_REVERB_INPUT_GAIN), 32'h1FFFF);
    program_register(SPARE_REG_ADDR, 32'hFFFF_FFFF);
    repeat (5) queue_sample(24'sh7FFFFF);
    repeat (5) queue_sample(24'sh800000);
    wait_until_quiet();

    // lengths above the line size, dry mixes, zero gains
    program_register(reg_addr(erdl_pkg::REG_ECHO_LENGTH), 32'h3FFFF);
    program_register(reg_addr(erdl_pkg::REG_REVERB_LENGTH), 32'd131073);
    program_register(reg_addr(erdl_pkg::REG_ECHO_MIX), 32'h0);
    program_register(reg_addr(erdl_pkg::REG_FEEDBACK_GAIN), 32'h0);
    program_register(reg_addr(erdl_pkg::REG_ECHO_INPUT_GAIN), 32'h0);
    program_register(reg_addr(erdl_pkg::REG_REVERB_MIX), 32'h0);
    program_register(reg_addr(erdl_pkg::REG_REVERB_INPUT_GAIN), 32'h0);
    pending_samples = '{24'sh7FFFFF, 24'sh800000, 24'sh123456, -24'sd2};
    wait_until_quiet();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 67; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 67; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      shuffle_settings();
      for (n = 0; n < 50; n++) queue_sample(random_sample());
      wait_until_quiet();
      for (n = 0; n < 50; n++) queue_sample(random_sample());
      wait_until_quiet();
    end

    if (error_count == 0) $display("echo_reverb_delay_lines_unit_test: clean");
    else $display("echo_reverb_delay_lines_unit_test: errors");
    $finish;
  end

endmodule

// File: sim.f
rtl/erdl_pkg.sv
rtl/erdl_ram.sv
rtl/erdl_regs.sv
rtl/erdl_ctrl.sv
rtl/erdl_dp.sv
rtl/echo_reverb_delay_lines_unit.sv
verif/echo_reverb_delay_lines_unit_test.sv
